// ===== rtl/shortest_job_first_scheduler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the shortest-job-first scheduler checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_ASSERT_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SJFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SJFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sjfs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sjfs_pkg
// Shared widths and types for the shortest-job-first scheduler.
// ---------------------------------------------------------------------------
package sjfs_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int IDX_W     = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int ARR_W     = 16;
    localparam int BUR_W     = 16;
    localparam int TIME_W    = 22;
    localparam int SUM_W     = 28;
    localparam int JOB_IDX_W = 6;

    // Write of one job into the cell that owns the given slot.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
    } load_t;

    // Marks the job in the given slot as finished.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } clear_t;

    // Candidate record that walks down the row of cells during a scan.
    // The r_ fields track the shortest ready job, the p_ fields the
    // pending job with the earliest arrival (shortest burst on a tie).
    typedef struct packed {
        logic             active;
        logic             r_vld;
        logic [IDX_W-1:0] r_idx;
        logic [ARR_W-1:0] r_arr;
        logic [BUR_W-1:0] r_bur;
        logic             p_vld;
        logic [IDX_W-1:0] p_idx;
        logic [ARR_W-1:0] p_arr;
        logic [BUR_W-1:0] p_bur;
    } token_t;

endpackage

// ===== rtl/sjfs_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sjfs_cell
// One job slot of the scheduler row: holds a job and merges it into the
// candidate record that passes through on its way to the next cell.
// ---------------------------------------------------------------------------
module sjfs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sjfs_pkg::IDX_W-1:0]    slot,
    input  logic [sjfs_pkg::TIME_W-1:0]   cur_time,
    input  sjfs_pkg::load_t               ld,
    input  sjfs_pkg::clear_t              clr,
    input  sjfs_pkg::token_t              tok_in,
    output sjfs_pkg::token_t              tok_out
);
    import sjfs_pkg::*;

    logic [ARR_W-1:0] arr_reg;
    logic [BUR_W-1:0] bur_reg;
    logic             live_reg;
    logic             live_next;
    token_t           tok_reg;
    token_t           tok_next;
    logic             is_ready;
    logic             take_r;
    logic             take_p;

    always_comb
    begin
        live_next = live_reg;
        if (ld.en && (ld.idx == slot))
        begin
            live_next = 1'b1;
        end
        else if (clr.en && (clr.idx == slot))
        begin
            live_next = 1'b0;
        end
    end

    // A job is ready once its arrival is not later than the clock.
    assign is_ready = live_reg && (TIME_W'(arr_reg) <= cur_time);
    // Strict compares keep the lower slot on a tie.
    assign take_r = is_ready && (!tok_in.r_vld || (bur_reg < tok_in.r_bur));
    assign take_p = live_reg && (!tok_in.p_vld || (arr_reg < tok_in.p_arr) ||
                    ((arr_reg == tok_in.p_arr) && (bur_reg < tok_in.p_bur)));

    always_comb
    begin
        tok_next = tok_in;
        if (take_r)
        begin
            tok_next.r_vld = 1'b1;
            tok_next.r_idx = slot;
            tok_next.r_arr = arr_reg;
            tok_next.r_bur = bur_reg;
        end
        if (take_p)
        begin
            tok_next.p_vld = 1'b1;
            tok_next.p_idx = slot;
            tok_next.p_arr = arr_reg;
            tok_next.p_bur = bur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            live_reg <= live_next;
            tok_reg  <= tok_next;
        end
    end

    // Job contents carry no reset; they are only read while live.
    always_ff @(posedge clk)
    begin
        if (ld.en && (ld.idx == slot))
        begin
            arr_reg <= ld.arr;
            bur_reg <= ld.bur;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/shortest_job_first_scheduler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shortest_job_first_scheduler
// Non-preemptive shortest-job-first scheduler built from a row of job cells.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake          Fields
//  --------  -----------------  ---------------------------------------------
//  job in    start & !busy      arrival_time, burst_length, last_job
//  result    done (one cycle)   job_index, wait_time, turnaround_time,
//                               total_wait, total_turnaround, last_result
//
// Jobs without last_job leave busy low.
// The transfer that carries last_job starts the schedule: for each result the
// controller injects the candidate record, lets it walk the row of cells and
// does the arithmetic in states S_CALC, S_SUM and S_TOTAL.
// Reset (rst_n low, asynchronous) empties every cell and returns to idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
// Operation
// Each job lives in its own cell. To choose the next job, the controller
// injects an empty candidate record into cell 0. On every clock the record
// moves one cell further, and each cell replaces the ready candidate when its
// job has arrived and has a shorter burst, and the pending candidate when its
// job arrives earlier (or at the same time with a shorter burst). Strict
// compares keep the lowest index on ties. When the record leaves the last
// cell, the controller takes the ready candidate, or, when no job is ready
// yet, the pending one and moves the clock forward to its arrival. Since no
// job was ready, every pending job arrives at or after that time, so the
// earliest-arrival, shortest-burst job is exactly the one the normal rule
// would pick once the clock has jumped.
// ---------------------------------------------------------------------------
module shortest_job_first_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sjfs_pkg::ARR_W-1:0]       arrival_time,
    input  logic [sjfs_pkg::BUR_W-1:0]       burst_length,
    input  logic                             last_job,
    output logic                             done,
    output logic [sjfs_pkg::JOB_IDX_W-1:0]   job_index,
    output logic [sjfs_pkg::TIME_W-1:0]      wait_time,
    output logic [sjfs_pkg::TIME_W-1:0]      turnaround_time,
    output logic [sjfs_pkg::SUM_W-1:0]       total_wait,
    output logic [sjfs_pkg::SUM_W-1:0]       total_turnaround,
    output logic                             last_result
);
    import sjfs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CALC  = 5'b00100,
        S_SUM   = 5'b01000,
        S_TOTAL = 5'b10000
    } state_t;

    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  left_reg,    left_next;
    logic [TIME_W-1:0] time_reg,    time_next;
    logic              inj_reg,     inj_next;
    logic [IDX_W-1:0]  sel_idx_reg, sel_idx_next;
    logic [ARR_W-1:0]  sel_arr_reg, sel_arr_next;
    logic [BUR_W-1:0]  sel_bur_reg, sel_bur_next;
    logic [TIME_W-1:0] begin_reg,   begin_next;
    logic [TIME_W-1:0] wait_reg,    wait_next;
    logic [TIME_W-1:0] end_reg,     end_next;
    logic [TIME_W-1:0] turn_reg,    turn_next;
    logic [SUM_W-1:0]  wsum_reg,    wsum_next;
    logic [SUM_W-1:0]  tsum_reg,    tsum_next;
    logic              last_reg,    last_next;
    logic              strobe_reg,  strobe_next;

    load_t             ld;
    clear_t            clr;
    token_t            tok [MAX_JOBS+1];

    // The head of the row sees an empty record, marked active on injection.
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = inj_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++)
        begin : g_cell
            sjfs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .slot     (IDX_W'(gi)),
                .cur_time (time_reg),
                .ld       (ld),
                .clr      (clr),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        time_next    = time_reg;
        inj_next     = 1'b0;
        sel_idx_next = sel_idx_reg;
        sel_arr_next = sel_arr_reg;
        sel_bur_next = sel_bur_reg;
        begin_next   = begin_reg;
        wait_next    = wait_reg;
        end_next     = end_reg;
        turn_next    = turn_reg;
        wsum_next    = wsum_reg;
        tsum_next    = tsum_reg;
        last_next    = last_reg;
        strobe_next  = 1'b0;
        ld           = '0;
        clr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // A job that finds the row full is dropped.
                    if (count_reg < CNT_W'(MAX_JOBS))
                    begin
                        ld.en      = 1'b1;
                        ld.idx     = count_reg[IDX_W-1:0];
                        ld.arr     = arrival_time;
                        ld.bur     = burst_length;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_job)
                    begin
                        left_next  = count_next;
                        time_next  = '0;
                        wsum_next  = '0;
                        tsum_next  = '0;
                        inj_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (tok[MAX_JOBS].active)
                begin
                    if (tok[MAX_JOBS].r_vld)
                    begin
                        sel_idx_next = tok[MAX_JOBS].r_idx;
                        sel_arr_next = tok[MAX_JOBS].r_arr;
                        sel_bur_next = tok[MAX_JOBS].r_bur;
                        begin_next   = time_reg;
                    end
                    else
                    begin
                        // Nothing has arrived yet: the clock jumps ahead.
                        sel_idx_next = tok[MAX_JOBS].p_idx;
                        sel_arr_next = tok[MAX_JOBS].p_arr;
                        sel_bur_next = tok[MAX_JOBS].p_bur;
                        begin_next   = TIME_W'(tok[MAX_JOBS].p_arr);
                    end
                    clr.en     = 1'b1;
                    clr.idx    = sel_idx_next;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                wait_next  = begin_reg - TIME_W'(sel_arr_reg);
                end_next   = begin_reg + TIME_W'(sel_bur_reg);
                state_next = S_SUM;
            end

            S_SUM:
            begin
                turn_next  = end_reg - TIME_W'(sel_arr_reg);
                wsum_next  = wsum_reg + SUM_W'(wait_reg);
                state_next = S_TOTAL;
            end

            S_TOTAL:
            begin
                tsum_next   = tsum_reg + SUM_W'(turn_reg);
                time_next   = end_reg;
                strobe_next = 1'b1;
                last_next   = (left_reg == CNT_W'(1));
                left_next   = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    inj_next   = 1'b1;
                    state_next = S_SCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            left_reg   <= '0;
            time_reg   <= '0;
            inj_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            wsum_reg   <= '0;
            tsum_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            time_reg   <= time_next;
            inj_reg    <= inj_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            wsum_reg   <= wsum_next;
            tsum_reg   <= tsum_next;
        end
    end

    // Datapath registers; they are always written before they are shown.
    always_ff @(posedge clk)
    begin
        sel_idx_reg <= sel_idx_next;
        sel_arr_reg <= sel_arr_next;
        sel_bur_reg <= sel_bur_next;
        begin_reg   <= begin_next;
        wait_reg    <= wait_next;
        end_reg     <= end_next;
        turn_reg    <= turn_next;
    end

    // Result fields hold steady after each strobe until work on the next result updates them.
    assign busy             = (state_reg != S_IDLE);
    assign done             = strobe_reg;
    assign job_index        = JOB_IDX_W'(sel_idx_reg);
    assign wait_time        = wait_reg;
    assign turnaround_time  = turn_reg;
    assign total_wait       = wsum_reg;
    assign total_turnaround = tsum_reg;
    assign last_result      = last_reg;

endmodule

// ===== rtl/sjfs_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sjfs_checker
// Port-level checks on the scheduler's command and result timing.
// ---------------------------------------------------------------------------
`include "shortest_job_first_scheduler_assert.svh"

module sjfs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_job,
    input logic done,
    input logic last_result
);

    // A loading transfer leaves the block free for the next job.
    `SJFS_ASSERT_NEXT(a_load_stays_idle, start && !busy && !last_job, !busy, "load made block busy")

    // The final job of a set starts the schedule.
    `SJFS_ASSERT_NEXT(a_last_starts, start && !busy && last_job, busy, "last job did not start")

    // The block stays busy between results and frees up with the final one.
    `SJFS_ASSERT_NOW(a_busy_on_result, done, busy == !last_result, "busy wrong at result")

    // Every result needs a full scan, so strobes never come back to back.
    `SJFS_ASSERT_NEXT(a_strobe_gap, done, !done, "back to back results")

endmodule

bind shortest_job_first_scheduler sjfs_checker u_sjfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_job    (last_job),
    .done        (done),
    .last_result (last_result)
);
